// File: hw/rtl/nteo_pkg.sv
// shared constants, item types and sequencer states for the neighbour table
package nteo_pkg;

  // table geometry
  localparam int MAX_NODES = 16;
  localparam int SLOT_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);

  // fixed field widths
  localparam int ID_W           = 32;
  localparam int TIME_W         = 32;
  localparam int RSSI_W         = 8;
  localparam int STAT_W         = 32;
  localparam int SLOT_FIELD_W   = 4;
  localparam int COUNT_FIELD_W  = 5;

  // one sighting
  typedef struct packed {
    logic [ID_W-1:0]          node_id;
    logic [TIME_W-1:0]        now_ms;
    logic signed [RSSI_W-1:0] rssi;
    logic                     has_info;
    logic [STAT_W-1:0]        uptime_sec;
    logic [STAT_W-1:0]        free_heap;
    logic [STAT_W-1:0]        remote_rx_count;
    logic [STAT_W-1:0]        remote_tx_count;
  } in_item_t;

  // one result
  typedef struct packed {
    logic                     accepted;
    logic                     was_known;
    logic [SLOT_FIELD_W-1:0]  slot;
    logic                     evicted;
    logic [ID_W-1:0]          evicted_id;
    logic [COUNT_FIELD_W-1:0] entry_count;
  } out_item_t;

  // table word read during the scan
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] last_seen;
    logic [RSSI_W-1:0] rssi;
  } entry_t;

  // status word, written only
  typedef struct packed {
    logic [STAT_W-1:0] uptime;
    logic [STAT_W-1:0] heap;
    logic [STAT_W-1:0] rx_count;
    logic [STAT_W-1:0] tx_count;
  } status_t;

  // read data handed to the scan unit
  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] idx;
    entry_t            word;
  } scan_rd_t;

  // scan outcome
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] match_idx;
    logic [SLOT_W-1:0] victim_idx;
    logic [ID_W-1:0]   victim_id;
  } scan_res_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WRITE
  } state_t;

endpackage

// File: hw/rtl/neighbor_table_oldest_evict_core.sv
// neighbour table top level: sequencer, table memories, config register and result register
// timing: an item with id zero gives its result in the cycle after acceptance;
//   any other item steps through ST_SCAN, ST_LAST and ST_WRITE before its result is registered
// flow: one item at a time, a new one accepted only in ST_IDLE; each item takes the accepting
//   idle cycle, a sweep of the single table read port, a drain and a write-back; id zero only the first
// reset: table count cleared to zero, self_id set to 1, sequencer idle; table contents
//   are not cleared; results are strobed for one cycle and the receiver cannot stall
module neighbor_table_oldest_evict_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  nteo_pkg::in_item_t          in_item,
  output logic                        out_valid,
  output nteo_pkg::out_item_t         out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [nteo_pkg::ID_W-1:0]   cfg_data
);
  import nteo_pkg::*;

  // table memories
  entry_t  entry_mem  [MAX_NODES];
  status_t status_mem [MAX_NODES];

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] scan_addr_r, scan_addr_nxt;
  logic [CNT_W-1:0]  valid_count_r, valid_count_nxt;
  logic [ID_W-1:0]   self_id_r;
  in_item_t          item_r;
  scan_rd_t          rd_r;
  scan_res_t         scan_res;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              accept;
  logic              rd_en;
  logic              wr_en;
  logic              full;
  logic [SLOT_W-1:0] wr_idx;
  status_t           wr_status;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign full      = (valid_count_r == CNT_W'(MAX_NODES));

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r <= ID_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      self_id_r <= cfg_data;
    end
  end

  // sequencer state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      scan_addr_r   <= '0;
      valid_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      scan_addr_r   <= scan_addr_nxt;
      valid_count_r <= valid_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // item capture and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (out_valid_nxt) begin
      out_r <= out_nxt;
    end
  end

  // slot choice for the write-back
  always_comb begin
    priority if (scan_res.found) begin
      wr_idx = scan_res.match_idx;
    end else if (!full) begin
      wr_idx = valid_count_r[SLOT_W-1:0];
    end else begin
      wr_idx = scan_res.victim_idx;
    end
  end

  // next state, memory control and result
  always_comb begin
    state_nxt       = state_r;
    scan_addr_nxt   = scan_addr_r;
    valid_count_nxt = valid_count_r;
    out_valid_nxt   = 1'b0;
    out_nxt         = '0;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        scan_addr_nxt = '0;
        if (accept) begin
          if (in_item.node_id == '0) begin
            out_valid_nxt       = 1'b1;
            out_nxt.entry_count = COUNT_FIELD_W'(valid_count_r);
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en         = 1'b1;
        scan_addr_nxt = scan_addr_r + 1'b1;
        if (scan_addr_r == SLOT_W'(MAX_NODES - 1)) begin
          scan_addr_nxt = '0;
          state_nxt     = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        wr_en     = 1'b1;
        state_nxt = ST_IDLE;
        if (!scan_res.found && !full) begin
          valid_count_nxt = valid_count_r + 1'b1;
        end
        out_valid_nxt      = 1'b1;
        out_nxt.accepted   = 1'b1;
        out_nxt.was_known  = scan_res.found;
        out_nxt.slot       = SLOT_FIELD_W'(wr_idx);
        out_nxt.evicted    = !scan_res.found && full;
        out_nxt.evicted_id = (!scan_res.found && full) ? scan_res.victim_id : '0;
        out_nxt.entry_count = COUNT_FIELD_W'(valid_count_nxt);
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // status word: new entries without info start cleared, known ones keep theirs without info
  always_comb begin
    if (item_r.has_info) begin
      wr_status.uptime   = item_r.uptime_sec;
      wr_status.heap     = item_r.free_heap;
      wr_status.rx_count = item_r.remote_rx_count;
      wr_status.tx_count = item_r.remote_tx_count;
    end else begin
      wr_status = '0;
    end
  end

  // entry memory: one read port for the sweep, one write port for write-back
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r.word <= entry_mem[scan_addr_r];
    end
    if (wr_en) begin
      entry_mem[wr_idx] <= {item_r.node_id, item_r.now_ms, item_r.rssi};
    end
  end

  // read tag travelling with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r.vld <= 1'b0;
    end else begin
      rd_r.vld <= rd_en;
    end
    rd_r.idx <= scan_addr_r;
  end

  // status memory
  always_ff @(posedge clk) begin
    if (wr_en && (!scan_res.found || item_r.has_info)) begin
      status_mem[wr_idx] <= wr_status;
    end
  end

  // match and victim search
  nteo_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (accept),
    .rd          (rd_r),
    .key_id      (item_r.node_id),
    .now_ms      (item_r.now_ms),
    .self_id     (self_id_r),
    .valid_count (valid_count_r),
    .res         (scan_res)
  );

  // checks
  a_write_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |=> out_valid_r)
    else $error("write-back not followed by a result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_count_r <= CNT_W'(MAX_NODES))
    else $error("entry count above table size");

  a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.evicted) |-> (out_r.entry_count == COUNT_FIELD_W'(MAX_NODES)))
    else $error("eviction while table not full");

  a_known_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.was_known) |-> (out_r.accepted && !out_r.evicted))
    else $error("known id reported as evicting");

  a_read_only_scanning: assert property (@(posedge clk) disable iff (!rst_n)
    rd_r.vld |-> ($past(state_r) == ST_SCAN))
    else $error("table read outside the sweep");

endmodule

// File: hw/rtl/nteo_scan.sv
// scan unit: finds the matching entry and the oldest evictable entry in one pass
module nteo_scan (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clear,
  input  nteo_pkg::scan_rd_t       rd,
  input  logic [nteo_pkg::ID_W-1:0]   key_id,
  input  logic [nteo_pkg::TIME_W-1:0] now_ms,
  input  logic [nteo_pkg::ID_W-1:0]   self_id,
  input  logic [nteo_pkg::CNT_W-1:0]  valid_count,
  output nteo_pkg::scan_res_t      res
);
  import nteo_pkg::*;

  logic              found_r;
  logic [SLOT_W-1:0] match_idx_r;
  logic              chosen_r;
  logic [TIME_W-1:0] best_age_r;
  logic [SLOT_W-1:0] victim_idx_r;
  logic [ID_W-1:0]   victim_id_r;
  logic [ID_W-1:0]   slot0_id_r;

  logic [TIME_W-1:0] age;
  logic              in_range;
  logic              is_match;
  logic              is_older;

  // per-entry compare
  always_comb begin
    age      = now_ms - rd.word.last_seen;
    in_range = CNT_W'(rd.idx) < valid_count;
    is_match = in_range && (rd.word.id == key_id);
    is_older = (rd.word.id != self_id) && (!chosen_r || (age > best_age_r));
  end

  // running match and oldest candidate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r      <= 1'b0;
      chosen_r     <= 1'b0;
      victim_idx_r <= '0;
    end else if (clear) begin
      found_r      <= 1'b0;
      chosen_r     <= 1'b0;
      victim_idx_r <= '0;
    end else if (rd.vld) begin
      if (!found_r && is_match) begin
        found_r     <= 1'b1;
        match_idx_r <= rd.idx;
      end
      if (is_older) begin
        chosen_r     <= 1'b1;
        best_age_r   <= age;
        victim_idx_r <= rd.idx;
        victim_id_r  <= rd.word.id;
      end
      if (rd.idx == '0) begin
        slot0_id_r <= rd.word.id;
      end
    end
  end

  // slot 0 stands in when nothing is evictable
  always_comb begin
    res.found      = found_r;
    res.match_idx  = match_idx_r;
    res.victim_idx = victim_idx_r;
    res.victim_id  = chosen_r ? victim_id_r : slot0_id_r;
  end

endmodule
